FILE: hw/rtl/tsspr_pkg.sv
// ----------------------------------------------------------------------------
// Two-stack swap/push/rotate engine: shared package
// Storage sizes, command codes, sequencer states and the memory port bundle.
// ----------------------------------------------------------------------------
package tsspr_pkg;

  localparam int unsigned DEPTH  = 512;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned CW     = $clog2(DEPTH + 1);
  localparam int unsigned SW     = CW + 1;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned SIZE_W = 10;

  typedef enum logic [3:0] {
    CMD_APPEND_A = 4'd0,
    CMD_SWAP_A   = 4'd1,
    CMD_SWAP_B   = 4'd2,
    CMD_MOVE_B_A = 4'd3,
    CMD_MOVE_A_B = 4'd4,
    CMD_ROT_A    = 4'd5,
    CMD_ROT_B    = 4'd6,
    CMD_RROT_A   = 4'd7,
    CMD_RROT_B   = 4'd8
  } cmd_e;

  typedef enum logic [1:0] {
    ST_APPLIED   = 2'd0,
    ST_NO_EFFECT = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    OP_APPEND,
    OP_SWAP,
    OP_ROT_UP,
    OP_ROT_DN,
    OP_MOVE
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADDR0,
    S_ADDR1,
    S_ADDR2,
    S_WR0,
    S_WR1,
    S_TOP,
    S_DONE
  } state_e;

  typedef struct packed {
    logic              we;
    logic [AW-1:0]     waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [AW-1:0]     raddr;
  } mem_req_t;

endpackage

FILE: hw/rtl/tsspr_stack_mem.sv
// ----------------------------------------------------------------------------
// Stack storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tsspr_stack_mem (
  input  logic                              clk_i,
  input  tsspr_pkg::mem_req_t               req_i,
  output logic [tsspr_pkg::DATA_W-1:0]      rdata_o
);

  logic [tsspr_pkg::DATA_W-1:0] mem_q [tsspr_pkg::DEPTH];
  logic [tsspr_pkg::DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // hold the last read word until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/tsspr_addr_unit.sv
// ----------------------------------------------------------------------------
// Ring address unit
// Computes (base + offset) mod DEPTH with one add and one compare-subtract.
// ----------------------------------------------------------------------------
module tsspr_addr_unit (
  input  logic [tsspr_pkg::AW-1:0] base_i,
  input  logic [tsspr_pkg::CW-1:0] off_i,
  output logic [tsspr_pkg::AW-1:0] addr_o
);

  logic [tsspr_pkg::SW-1:0] sum;
  logic [tsspr_pkg::SW-1:0] sum_wrap;

  assign sum      = tsspr_pkg::SW'(base_i) + tsspr_pkg::SW'(off_i);
  assign sum_wrap = sum - tsspr_pkg::SW'(tsspr_pkg::DEPTH);
  assign addr_o   = (sum >= tsspr_pkg::SW'(tsspr_pkg::DEPTH)) ?
                    sum_wrap[tsspr_pkg::AW-1:0] : sum[tsspr_pkg::AW-1:0];

endmodule

FILE: hw/rtl/two_stack_swap_push_rotate.sv
// ----------------------------------------------------------------------------
// Two-stack swap/push/rotate engine (top level)
// An append writes one word, a swap reads two words and writes them back
// exchanged, a rotate or move reads one word and writes it; a command with no
// effect or a refused append only reads the tops. One word at a time: the next
// word is taken once the result is registered, and the sequencer steps are
// set by the single ring address unit and the one write port of each stack memory.
// Reset clears both heads and fills; the stack memories are not cleared.
// ----------------------------------------------------------------------------
module two_stack_swap_push_rotate (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [3:0]                            command_i,
  input  logic signed [31:0]                    load_value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [1:0]                            status_o,
  output logic signed [31:0]                    top_of_a_o,
  output logic signed [31:0]                    top_of_b_o,
  output logic [tsspr_pkg::SIZE_W-1:0]          size_of_a_o,
  output logic [tsspr_pkg::SIZE_W-1:0]          size_of_b_o
);

  localparam int unsigned AW = tsspr_pkg::AW;
  localparam int unsigned CW = tsspr_pkg::CW;
  localparam int unsigned SW = tsspr_pkg::SW;
  localparam int unsigned DW = tsspr_pkg::DATA_W;

  tsspr_pkg::state_e  state_q, state_d;
  tsspr_pkg::op_e     op_q, op_d;
  tsspr_pkg::status_e st_q, st_d;
  logic               sel_q, sel_d;
  logic [DW-1:0]      load_q;

  logic [AW-1:0] head_q [2];
  logic [AW-1:0] head_d [2];
  logic [CW-1:0] fill_q [2];
  logic [CW-1:0] fill_d [2];

  logic [AW-1:0] addr0_q, addr1_q, inc_q;
  logic [DW-1:0] data0_q;

  logic [AW-1:0] au_base;
  logic [CW-1:0] au_off;
  logic [AW-1:0] au_addr;

  tsspr_pkg::mem_req_t req   [2];
  logic [DW-1:0]       rdata [2];

  logic                   accept;
  logic                   out_load;
  logic                   out_valid_q;
  logic [1:0]             status_q;
  logic [DW-1:0]          top_a_q, top_b_q;
  logic [CW-1:0]          size_a_q, size_b_q;
  logic [SW-1:0]          total;

  assign in_stall_o = (state_q != tsspr_pkg::S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign total      = SW'(fill_q[0]) + SW'(fill_q[1]);

  tsspr_stack_mem u_mem_a (
    .clk_i   (clk_i),
    .req_i   (req[0]),
    .rdata_o (rdata[0])
  );

  tsspr_stack_mem u_mem_b (
    .clk_i   (clk_i),
    .req_i   (req[1]),
    .rdata_o (rdata[1])
  );

  tsspr_addr_unit u_addr (
    .base_i (au_base),
    .off_i  (au_off),
    .addr_o (au_addr)
  );

  // operand select for the shared address unit
  always_comb begin
    au_base = head_q[sel_q];
    au_off  = '0;
    case (state_q)
      tsspr_pkg::S_ADDR0: begin
        case (op_q)
          tsspr_pkg::OP_APPEND: au_off = fill_q[sel_q];
          tsspr_pkg::OP_ROT_DN: au_off = fill_q[sel_q] - CW'(1);
          default:              au_off = '0;
        endcase
      end
      tsspr_pkg::S_ADDR1: begin
        case (op_q)
          tsspr_pkg::OP_SWAP:   au_off = CW'(1);
          tsspr_pkg::OP_ROT_UP: au_off = fill_q[sel_q];
          tsspr_pkg::OP_MOVE: begin
            au_base = head_q[~sel_q];
            au_off  = CW'(tsspr_pkg::DEPTH - 1);
          end
          default:              au_off = CW'(tsspr_pkg::DEPTH - 1);
        endcase
      end
      tsspr_pkg::S_ADDR2: au_off = CW'(1);
      default:            au_off = '0;
    endcase
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    st_d       = st_q;
    sel_d      = sel_q;
    head_d[0]  = head_q[0];
    head_d[1]  = head_q[1];
    fill_d[0]  = fill_q[0];
    fill_d[1]  = fill_q[1];
    req[0]     = '0;
    req[1]     = '0;
    out_load   = 1'b0;

    case (state_q)
      tsspr_pkg::S_IDLE: begin
        if (accept) begin
          st_d = tsspr_pkg::ST_NO_EFFECT;
          op_d = tsspr_pkg::OP_SWAP;
          sel_d = 1'b0;
          case (command_i)
            tsspr_pkg::CMD_APPEND_A: begin
              op_d = tsspr_pkg::OP_APPEND;
              st_d = (total >= SW'(tsspr_pkg::DEPTH)) ? tsspr_pkg::ST_FULL
                                                       : tsspr_pkg::ST_APPLIED;
            end
            tsspr_pkg::CMD_SWAP_A, tsspr_pkg::CMD_SWAP_B: begin
              sel_d = (command_i == tsspr_pkg::CMD_SWAP_B);
              if (fill_q[sel_d] >= CW'(2)) st_d = tsspr_pkg::ST_APPLIED;
            end
            tsspr_pkg::CMD_MOVE_B_A, tsspr_pkg::CMD_MOVE_A_B: begin
              op_d  = tsspr_pkg::OP_MOVE;
              sel_d = (command_i == tsspr_pkg::CMD_MOVE_B_A);
              if (fill_q[sel_d] != '0) st_d = tsspr_pkg::ST_APPLIED;
            end
            tsspr_pkg::CMD_ROT_A, tsspr_pkg::CMD_ROT_B: begin
              op_d  = tsspr_pkg::OP_ROT_UP;
              sel_d = (command_i == tsspr_pkg::CMD_ROT_B);
              if (fill_q[sel_d] >= CW'(2)) st_d = tsspr_pkg::ST_APPLIED;
            end
            tsspr_pkg::CMD_RROT_A, tsspr_pkg::CMD_RROT_B: begin
              op_d  = tsspr_pkg::OP_ROT_DN;
              sel_d = (command_i == tsspr_pkg::CMD_RROT_B);
              if (fill_q[sel_d] >= CW'(2)) st_d = tsspr_pkg::ST_APPLIED;
            end
            default: st_d = tsspr_pkg::ST_NO_EFFECT;
          endcase
          state_d = (st_d == tsspr_pkg::ST_APPLIED) ? tsspr_pkg::S_ADDR0
                                                    : tsspr_pkg::S_TOP;
        end
      end
      tsspr_pkg::S_ADDR0: begin
        state_d = (op_q == tsspr_pkg::OP_APPEND) ? tsspr_pkg::S_WR0
                                                 : tsspr_pkg::S_ADDR1;
      end
      tsspr_pkg::S_ADDR1: begin
        req[sel_q].re    = 1'b1;
        req[sel_q].raddr = addr0_q;
        state_d          = tsspr_pkg::S_ADDR2;
      end
      tsspr_pkg::S_ADDR2: begin
        // second operand of a swap
        if (op_q == tsspr_pkg::OP_SWAP) begin
          req[sel_q].re    = 1'b1;
          req[sel_q].raddr = addr1_q;
        end
        state_d = tsspr_pkg::S_WR0;
      end
      tsspr_pkg::S_WR0: begin
        state_d = tsspr_pkg::S_TOP;
        case (op_q)
          tsspr_pkg::OP_APPEND: begin
            req[0].we    = 1'b1;
            req[0].waddr = addr0_q;
            req[0].wdata = load_q;
            fill_d[0]    = fill_q[0] + CW'(1);
          end
          tsspr_pkg::OP_SWAP: begin
            req[sel_q].we    = 1'b1;
            req[sel_q].waddr = addr0_q;
            req[sel_q].wdata = rdata[sel_q];
            state_d          = tsspr_pkg::S_WR1;
          end
          tsspr_pkg::OP_ROT_UP: begin
            req[sel_q].we    = 1'b1;
            req[sel_q].waddr = addr1_q;
            req[sel_q].wdata = data0_q;
            head_d[sel_q]    = inc_q;
          end
          tsspr_pkg::OP_ROT_DN: begin
            req[sel_q].we    = 1'b1;
            req[sel_q].waddr = addr1_q;
            req[sel_q].wdata = data0_q;
            head_d[sel_q]    = addr1_q;
          end
          tsspr_pkg::OP_MOVE: begin
            req[~sel_q].we    = 1'b1;
            req[~sel_q].waddr = addr1_q;
            req[~sel_q].wdata = data0_q;
            head_d[~sel_q]    = addr1_q;
            fill_d[~sel_q]    = fill_q[~sel_q] + CW'(1);
            head_d[sel_q]     = inc_q;
            fill_d[sel_q]     = fill_q[sel_q] - CW'(1);
          end
          default: state_d = tsspr_pkg::S_TOP;
        endcase
      end
      tsspr_pkg::S_WR1: begin
        req[sel_q].we    = 1'b1;
        req[sel_q].waddr = addr1_q;
        req[sel_q].wdata = data0_q;
        state_d          = tsspr_pkg::S_TOP;
      end
      tsspr_pkg::S_TOP: begin
        req[0].re    = 1'b1;
        req[0].raddr = head_q[0];
        req[1].re    = 1'b1;
        req[1].raddr = head_q[1];
        state_d      = tsspr_pkg::S_DONE;
      end
      tsspr_pkg::S_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = tsspr_pkg::S_IDLE;
        end
      end
      default: state_d = tsspr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tsspr_pkg::S_IDLE;
      op_q        <= tsspr_pkg::OP_APPEND;
      st_q        <= tsspr_pkg::ST_NO_EFFECT;
      sel_q       <= 1'b0;
      head_q[0]   <= '0;
      head_q[1]   <= '0;
      fill_q[0]   <= '0;
      fill_q[1]   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      st_q        <= st_d;
      sel_q       <= sel_d;
      head_q[0]   <= head_d[0];
      head_q[1]   <= head_d[1];
      fill_q[0]   <= fill_d[0];
      fill_q[1]   <= fill_d[1];
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      load_q <= load_value_i;
    end
    if (state_q == tsspr_pkg::S_ADDR0) begin
      addr0_q <= au_addr;
    end
    if (state_q == tsspr_pkg::S_ADDR1) begin
      addr1_q <= au_addr;
    end
    if (state_q == tsspr_pkg::S_ADDR2) begin
      inc_q   <= au_addr;
      data0_q <= rdata[sel_q];
    end
    if (out_load) begin
      status_q <= st_q;
      top_a_q  <= (fill_q[0] == '0) ? '0 : rdata[0];
      top_b_q  <= (fill_q[1] == '0) ? '0 : rdata[1];
      size_a_q <= fill_q[0];
      size_b_q <= fill_q[1];
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign top_of_a_o  = top_a_q;
  assign top_of_b_o  = top_b_q;
  assign size_of_a_o = tsspr_pkg::SIZE_W'(size_a_q);
  assign size_of_b_o = tsspr_pkg::SIZE_W'(size_b_q);

  // the combined fill of both stacks stays within the depth of one store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    total <= SW'(tsspr_pkg::DEPTH))
    else $error("combined fill exceeds store depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (SW'(head_q[0]) < SW'(tsspr_pkg::DEPTH)) && (SW'(head_q[1]) < SW'(tsspr_pkg::DEPTH)))
    else $error("head index out of ring");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != tsspr_pkg::S_WR0) |=> ($stable(fill_q[0]) && $stable(fill_q[1])))
    else $error("fill changed outside write step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != tsspr_pkg::S_IDLE))
    else $error("accepted word did not start the sequencer");

endmodule

FILE: test/two_stack_swap_push_rotate_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-stack swap/push/rotate engine: self-checking testbench
// Drives command words through the valid/stall input channel and mirrors
// every accepted command in a local model of both ring-buffer stacks. Each
// result word is compared, field by field, with the oldest prediction.
// Covers empty and one-entry stacks, a full store, unused codes, random
// idling on both channels and a long output hold-off.
// ----------------------------------------------------------------------------
module two_stack_swap_push_rotate_test;

  localparam int          LANE_A         = 0;
  localparam int          LANE_B         = 1;
  localparam logic [3:0]  FIRST_UNUSED   = 4'(tsspr_pkg::CMD_RROT_B) + 4'd1;
  localparam logic [3:0]  LAST_UNUSED    = 4'hF;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          HOLD_OFF_LEN   = 400;
  localparam int          SETTLE_CYCLES  = 16;
  localparam int          MAX_REPORTS    = 10;

  typedef struct packed {
    tsspr_pkg::status_e                status;
    logic [31:0]                       top_a;
    logic [31:0]                       top_b;
    logic [tsspr_pkg::SIZE_W-1:0]      size_a;
    logic [tsspr_pkg::SIZE_W-1:0]      size_b;
  } stack_view_t;

  logic                      clk_i        = 1'b0;
  logic                      rst_ni       = 1'b0;
  logic                      in_valid_i   = 1'b0;
  logic                      in_stall_o;
  logic [3:0]                command_i    = '0;
  logic signed [31:0]        load_value_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i  = 1'b0;
  logic [1:0]                status_o;
  logic signed [31:0]        top_of_a_o;
  logic signed [31:0]        top_of_b_o;
  logic [tsspr_pkg::SIZE_W-1:0] size_of_a_o;
  logic [tsspr_pkg::SIZE_W-1:0] size_of_b_o;

  // Local copy of both stacks
  logic [31:0]               lane_mem  [2][tsspr_pkg::DEPTH];
  logic [tsspr_pkg::AW-1:0]  lane_head [2];
  int unsigned               lane_fill [2];

  stack_view_t               expected_views[$];
  int                        mismatch_count = 0;
  int                        quiet_cycles   = 0;
  int                        hold_off_left  = 0;
  int unsigned               send_idle_pct  = 0;
  int unsigned               recv_idle_pct  = 0;

  two_stack_swap_push_rotate u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .load_value_i (load_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .top_of_a_o   (top_of_a_o),
    .top_of_b_o   (top_of_b_o),
    .size_of_a_o  (size_of_a_o),
    .size_of_b_o  (size_of_b_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- model

  function automatic logic [tsspr_pkg::AW-1:0] lane_slot(int lane, int unsigned k);
    return lane_head[lane] + tsspr_pkg::AW'(k);
  endfunction

  function automatic tsspr_pkg::status_e swap_top_pair(int lane);
    logic [31:0] held;
    if (lane_fill[lane] < 2) return tsspr_pkg::ST_NO_EFFECT;
    held = lane_mem[lane][lane_slot(lane, 0)];
    lane_mem[lane][lane_slot(lane, 0)] = lane_mem[lane][lane_slot(lane, 1)];
    lane_mem[lane][lane_slot(lane, 1)] = held;
    return tsspr_pkg::ST_APPLIED;
  endfunction

  // Top goes to the bottom; on a full lane only the head moves.
  function automatic tsspr_pkg::status_e rotate_up(int lane);
    logic [31:0] held;
    if (lane_fill[lane] < 2) return tsspr_pkg::ST_NO_EFFECT;
    held = lane_mem[lane][lane_slot(lane, 0)];
    lane_mem[lane][lane_slot(lane, lane_fill[lane])] = held;
    lane_head[lane] = lane_head[lane] + tsspr_pkg::AW'(1);
    return tsspr_pkg::ST_APPLIED;
  endfunction

  function automatic tsspr_pkg::status_e rotate_down(int lane);
    logic [31:0] held;
    if (lane_fill[lane] < 2) return tsspr_pkg::ST_NO_EFFECT;
    held = lane_mem[lane][lane_slot(lane, lane_fill[lane] - 1)];
    lane_head[lane] = lane_head[lane] - tsspr_pkg::AW'(1);
    lane_mem[lane][lane_head[lane]] = held;
    return tsspr_pkg::ST_APPLIED;
  endfunction

  function automatic tsspr_pkg::status_e move_top(int from_lane, int to_lane);
    logic [31:0] held;
    if (lane_fill[from_lane] == 0) return tsspr_pkg::ST_NO_EFFECT;
    held = lane_mem[from_lane][lane_head[from_lane]];
    lane_head[from_lane] = lane_head[from_lane] + tsspr_pkg::AW'(1);
    lane_fill[from_lane]--;
    lane_head[to_lane] = lane_head[to_lane] - tsspr_pkg::AW'(1);
    lane_mem[to_lane][lane_head[to_lane]] = held;
    lane_fill[to_lane]++;
    return tsspr_pkg::ST_APPLIED;
  endfunction

  function automatic tsspr_pkg::status_e append_bottom(logic [31:0] value);
    if (lane_fill[LANE_A] + lane_fill[LANE_B] >= tsspr_pkg::DEPTH) return tsspr_pkg::ST_FULL;
    lane_mem[LANE_A][lane_slot(LANE_A, lane_fill[LANE_A])] = value;
    lane_fill[LANE_A]++;
    return tsspr_pkg::ST_APPLIED;
  endfunction

  function automatic stack_view_t apply_command(logic [3:0] cmd, logic [31:0] value);
    stack_view_t view;
    case (cmd)
      tsspr_pkg::CMD_APPEND_A: view.status = append_bottom(value);
      tsspr_pkg::CMD_SWAP_A:   view.status = swap_top_pair(LANE_A);
      tsspr_pkg::CMD_SWAP_B:   view.status = swap_top_pair(LANE_B);
      tsspr_pkg::CMD_MOVE_B_A: view.status = move_top(LANE_B, LANE_A);
      tsspr_pkg::CMD_MOVE_A_B: view.status = move_top(LANE_A, LANE_B);
      tsspr_pkg::CMD_ROT_A:    view.status = rotate_up(LANE_A);
      tsspr_pkg::CMD_ROT_B:    view.status = rotate_up(LANE_B);
      tsspr_pkg::CMD_RROT_A:   view.status = rotate_down(LANE_A);
      tsspr_pkg::CMD_RROT_B:   view.status = rotate_down(LANE_B);
      default:                 view.status = tsspr_pkg::ST_NO_EFFECT;
    endcase
    view.top_a  = lane_fill[LANE_A] != 0 ? lane_mem[LANE_A][lane_head[LANE_A]] : '0;
    view.top_b  = lane_fill[LANE_B] != 0 ? lane_mem[LANE_B][lane_head[LANE_B]] : '0;
    view.size_a = tsspr_pkg::SIZE_W'(lane_fill[LANE_A]);
    view.size_b = tsspr_pkg::SIZE_W'(lane_fill[LANE_B]);
    return view;
  endfunction

  // ---------------------------------------------------------- stimulus

  function automatic logic [31:0] pick_load_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [3:0] pick_command(int unsigned append_pct);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < append_pct) return tsspr_pkg::CMD_APPEND_A;
    if (roll < append_pct + 3) return 4'($urandom_range(LAST_UNUSED, FIRST_UNUSED));
    return 4'($urandom_range(tsspr_pkg::CMD_RROT_B, tsspr_pkg::CMD_SWAP_A));
  endfunction

  // Offer one word and record its prediction once it is taken.
  task automatic send_command(logic [3:0] cmd, logic [31:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    load_value_i <= value;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    expected_views.push_back(apply_command(cmd, value));
  endtask

  // Hold the input until every predicted word has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_views.size() != 0);
  endtask

  task automatic test_directed_cases();
    // every operation on two empty stacks
    send_command(tsspr_pkg::CMD_SWAP_A, $urandom);
    send_command(tsspr_pkg::CMD_SWAP_B, $urandom);
    send_command(tsspr_pkg::CMD_MOVE_B_A, $urandom);
    send_command(tsspr_pkg::CMD_MOVE_A_B, $urandom);
    send_command(tsspr_pkg::CMD_ROT_A, $urandom);
    send_command(tsspr_pkg::CMD_ROT_B, $urandom);
    send_command(tsspr_pkg::CMD_RROT_A, $urandom);
    send_command(tsspr_pkg::CMD_RROT_B, $urandom);
    send_command(tsspr_pkg::CMD_APPEND_A, 32'h8000_0000);
    send_command(tsspr_pkg::CMD_SWAP_A, $urandom);
    send_command(tsspr_pkg::CMD_APPEND_A, 32'h7FFF_FFFF);
    send_command(tsspr_pkg::CMD_APPEND_A, '0);
    send_command(tsspr_pkg::CMD_APPEND_A, '1);
    send_command(tsspr_pkg::CMD_APPEND_A, 32'hAAAA_AAAA);
    send_command(tsspr_pkg::CMD_SWAP_A, $urandom);
    send_command(tsspr_pkg::CMD_ROT_A, $urandom);
    send_command(tsspr_pkg::CMD_RROT_A, $urandom);
    send_command(tsspr_pkg::CMD_MOVE_A_B, $urandom);
    // one entry on B
    send_command(tsspr_pkg::CMD_RROT_B, $urandom);
    send_command(tsspr_pkg::CMD_MOVE_A_B, $urandom);
    send_command(tsspr_pkg::CMD_SWAP_B, $urandom);
    send_command(tsspr_pkg::CMD_ROT_B, $urandom);
    send_command(tsspr_pkg::CMD_MOVE_B_A, $urandom);
    send_command(FIRST_UNUSED, $urandom);
    send_command(LAST_UNUSED, $urandom);
  endtask

  task automatic test_random_mix(int count, int unsigned append_pct);
    repeat (count) send_command(pick_command(append_pct), pick_load_value());
  endtask

  // Pack every entry into A, hit the full store, then rotate, swap and move with the store full.
  task automatic test_fill_to_capacity();
    while (lane_fill[LANE_B] != 0) send_command(tsspr_pkg::CMD_MOVE_B_A, $urandom);
    while (lane_fill[LANE_A] < tsspr_pkg::DEPTH)
      send_command(tsspr_pkg::CMD_APPEND_A, pick_load_value());
    send_command(tsspr_pkg::CMD_APPEND_A, pick_load_value());
    send_command(tsspr_pkg::CMD_ROT_A, $urandom);
    send_command(tsspr_pkg::CMD_ROT_A, $urandom);
    send_command(tsspr_pkg::CMD_RROT_A, $urandom);
    send_command(tsspr_pkg::CMD_SWAP_A, $urandom);
    send_command(tsspr_pkg::CMD_RROT_A, $urandom);
    send_command(tsspr_pkg::CMD_MOVE_A_B, $urandom);
    send_command(tsspr_pkg::CMD_APPEND_A, pick_load_value());
    send_command(tsspr_pkg::CMD_MOVE_A_B, $urandom);
    send_command(tsspr_pkg::CMD_SWAP_B, $urandom);
    send_command(tsspr_pkg::CMD_MOVE_B_A, $urandom);
    send_command(tsspr_pkg::CMD_APPEND_A, pick_load_value());
  endtask

  // Stall the output long enough that the block backs up onto its input.
  task automatic test_output_backpressure();
    hold_off_left = HOLD_OFF_LEN;
    repeat (40) send_command(pick_command(25), pick_load_value());
    drain_results();
  endtask

  // ------------------------------------------------------------ receiver

  always @(posedge clk_i) begin
    if (hold_off_left > 0) begin
      out_stall_i <= 1'b1;
      hold_off_left--;
    end else begin
      out_stall_i <= $urandom_range(99) < recv_idle_pct;
    end
  end

  task automatic flag_mismatch(string field, logic [31:0] want, logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %08h, got %08h", $realtime, field, want, got);
  endtask

  always @(posedge clk_i) begin
    stack_view_t want;
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      if (expected_views.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: result word with nothing predicted", $realtime);
      end else begin
        want = expected_views.pop_front();
        if (status_o !== want.status)
          flag_mismatch("status", 32'(want.status), 32'(status_o));
        if (top_of_a_o !== want.top_a)   flag_mismatch("top_of_a", want.top_a, top_of_a_o);
        if (top_of_b_o !== want.top_b)   flag_mismatch("top_of_b", want.top_b, top_of_b_o);
        if (size_of_a_o !== want.size_a)
          flag_mismatch("size_of_a", 32'(want.size_a), 32'(size_of_a_o));
        if (size_of_b_o !== want.size_b)
          flag_mismatch("size_of_b", 32'(want.size_b), 32'(size_of_b_o));
      end
    end
  end

  // Stop the run if neither channel moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_stall_o === 1'b0) ||
        (out_valid_o === 1'b1 && !out_stall_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("two_stack_swap_push_rotate verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- run

  initial begin
    lane_head[LANE_A] = '0;
    lane_head[LANE_B] = '0;
    lane_fill[LANE_A] = 0;
    lane_fill[LANE_B] = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 36;
    recv_idle_pct = 71;
    test_directed_cases();
    test_random_mix(250, 15);
    drain_results();

    send_idle_pct = 71;
    recv_idle_pct = 36;
    test_fill_to_capacity();
    test_random_mix(200, 30);
    drain_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_output_backpressure();
    test_random_mix(150, 20);
    drain_results();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_views.size() == 0)
      $display("two_stack_swap_push_rotate verification clean");
    else
      $display("two_stack_swap_push_rotate verification failed");
    $finish;
  end

endmodule

FILE: two_stack_swap_push_rotate.f
hw/rtl/tsspr_pkg.sv
hw/rtl/tsspr_stack_mem.sv
hw/rtl/tsspr_addr_unit.sv
hw/rtl/two_stack_swap_push_rotate.sv
test/two_stack_swap_push_rotate_test.sv
